FILE: rtl/ofb_pkg.sv
`default_nettype none

package ofb_pkg;

    localparam int CFG_W            = 7;
    localparam int CFG_IDX_W        = 2;
    localparam int IN_SAMPLE_W      = 32;
    localparam int FRAME_W          = 32;
    localparam int POS_W            = 6;
    localparam int MAX_WINDOW_DEF   = 64;
    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int WINDOW_RESET     = 32;
    localparam int HOP_RESET        = 16;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HOP    = CFG_IDX_W'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_REPLAY,
        S_DROP,
        S_EMIT,
        S_WRITE
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/overlapping_frame_buffer.sv
// Inside a frame an accepted item passes to the emit state, where its own result is registered
// once the output is free; a frame start first replays the stored overlap, through a read and a
// replay state per entry, then the drop state removes the hop entries before the item's own result.
// No new item is taken until the write state has finished the last one, and a stalled output
// holds it; this pace is set by the single ring memory port and the shared modulo adder.
// Reset: synchronous active-low reset empties the ring, clears the position and frame
// counters and restores window length 32 and hop length 16.
`default_nettype none

module overlapping_frame_buffer #(
    parameter int MAX_WINDOW   = ofb_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_WIDTH = ofb_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [ofb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [ofb_pkg::CFG_W-1:0]       i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [ofb_pkg::IN_SAMPLE_W-1:0] i_sample_in,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [ofb_pkg::FRAME_W-1:0]          o_frame_number,
    output logic [ofb_pkg::POS_W-1:0]            o_frame_position,
    output logic [ofb_pkg::IN_SAMPLE_W-1:0]      o_sample_out,
    output logic                                 o_last_of_run
);

    localparam int CFG_W      = ofb_pkg::CFG_W;
    localparam int RING_DEPTH = MAX_WINDOW - 1;
    localparam int AW         = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW         = $clog2(MAX_WINDOW);
    localparam int KW         = (CW > CFG_W) ? CW : CFG_W;
    localparam int SW         = ((AW > KW) ? AW : KW) + 1;
    localparam int DW         = (SAMPLE_WIDTH < ofb_pkg::IN_SAMPLE_W) ?
                                SAMPLE_WIDTH : ofb_pkg::IN_SAMPLE_W;
    localparam logic [CFG_W-1:0] MAX_W =
        (MAX_WINDOW > (2 ** CFG_W) - 1) ? {CFG_W{1'b1}} : CFG_W'(MAX_WINDOW);
    localparam logic [SW-1:0] DEPTH_S = SW'(RING_DEPTH);

    logic [DW-1:0] r_ring [RING_DEPTH];

    ofb_pkg::t_state r_state, n_state;
    logic [CFG_W-1:0]   r_win, n_win, r_hop, n_hop;
    logic [CFG_W-1:0]   r_h, n_h, r_cap, n_cap;
    logic [CFG_W-1:0]   r_pos, n_pos;
    logic [AW-1:0]      r_head, n_head;
    logic [CW-1:0]      r_count, n_count;
    logic [ofb_pkg::FRAME_W-1:0] r_frame, n_frame;
    logic [DW-1:0]      r_s, n_s;
    logic [DW-1:0]      r_rd;
    logic               r_ov, n_ov;
    logic [ofb_pkg::FRAME_W-1:0]     r_o_frame, n_o_frame;
    logic [ofb_pkg::POS_W-1:0]       r_o_pos, n_o_pos;
    logic [ofb_pkg::IN_SAMPLE_W-1:0] r_o_sample, n_o_sample;
    logic               r_o_last, n_o_last;

    logic [CFG_W-1:0] w_eff, h_eff;
    logic [KW-1:0]    opb, drop_n, trim_n;
    logic [SW-1:0]    sum;
    logic [AW-1:0]    mod_res;
    logic             slot_free, store, full;

    // Shared modulo adder over the ring depth.
    always_comb begin
        sum     = SW'(r_head) + SW'(opb);
        mod_res = (sum >= DEPTH_S) ? AW'(sum - DEPTH_S) : AW'(sum);
    end

    always_comb begin
        w_eff  = (r_win < CFG_W'(2)) ? CFG_W'(2) : ((r_win > MAX_W) ? MAX_W : r_win);
        h_eff  = (r_hop < CFG_W'(1)) ? CFG_W'(1) : ((r_hop > w_eff) ? w_eff : r_hop);
        drop_n = (KW'(r_h) < KW'(r_count)) ? KW'(r_h) : KW'(r_count);
        trim_n = KW'(r_count) - KW'(r_cap) + KW'(1);
        store  = (r_pos >= r_h) && (r_cap != '0);
        full   = KW'(r_count) >= KW'(r_cap);
        slot_free = !r_ov || i_out_ready;
    end

    always_comb begin
        n_state    = r_state;
        n_win      = r_win;
        n_hop      = r_hop;
        n_h        = r_h;
        n_cap      = r_cap;
        n_pos      = r_pos;
        n_head     = r_head;
        n_count    = r_count;
        n_frame    = r_frame;
        n_s        = r_s;
        n_ov       = r_ov && !i_out_ready;
        n_o_frame  = r_o_frame;
        n_o_pos    = r_o_pos;
        n_o_sample = r_o_sample;
        n_o_last   = r_o_last;
        opb        = '0;
        o_in_ready = 1'b0;

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ofb_pkg::REG_WINDOW: n_win = i_cfg_data;
                ofb_pkg::REG_HOP:    n_hop = i_cfg_data;
                default: ;
            endcase
        end

        unique case (r_state)
            ofb_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_s   = i_sample_in[DW-1:0];
                    n_h   = h_eff;
                    n_cap = w_eff - h_eff;
                    if (r_pos >= w_eff) begin
                        n_frame = r_frame + 1'b1;
                        n_pos   = '0;
                        n_state = (r_count != '0) ? ofb_pkg::S_READ : ofb_pkg::S_DROP;
                    end else begin
                        n_state = ofb_pkg::S_EMIT;
                    end
                end
            end
            ofb_pkg::S_READ: begin
                opb     = KW'(r_pos);
                n_state = ofb_pkg::S_REPLAY;
            end
            ofb_pkg::S_REPLAY: begin
                if (slot_free) begin
                    n_ov       = 1'b1;
                    n_o_frame  = r_frame;
                    n_o_pos    = r_pos[ofb_pkg::POS_W-1:0];
                    n_o_sample = ofb_pkg::IN_SAMPLE_W'(r_rd);
                    n_o_last   = 1'b0;
                    n_pos      = r_pos + 1'b1;
                    if (KW'(r_pos) + KW'(1) == KW'(r_count)) begin
                        n_state = ofb_pkg::S_DROP;
                    end else begin
                        n_state = ofb_pkg::S_READ;
                    end
                end
            end
            ofb_pkg::S_DROP: begin
                opb     = drop_n;
                n_head  = mod_res;
                n_count = r_count - CW'(drop_n);
                n_state = ofb_pkg::S_EMIT;
            end
            ofb_pkg::S_EMIT: begin
                opb = trim_n;
                if (slot_free) begin
                    n_ov       = 1'b1;
                    n_o_frame  = r_frame;
                    n_o_pos    = r_pos[ofb_pkg::POS_W-1:0];
                    n_o_sample = ofb_pkg::IN_SAMPLE_W'(r_s);
                    n_o_last   = 1'b1;
                    if (store && full) begin
                        n_head  = mod_res;
                        n_count = CW'(r_cap - CFG_W'(1));
                    end
                    n_state = ofb_pkg::S_WRITE;
                end
            end
            ofb_pkg::S_WRITE: begin
                opb = KW'(r_count);
                if (store) begin
                    n_count = r_count + 1'b1;
                end
                n_pos   = r_pos + 1'b1;
                n_state = ofb_pkg::S_IDLE;
            end
            default: n_state = ofb_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ofb_pkg::S_IDLE;
            r_win   <= CFG_W'(ofb_pkg::WINDOW_RESET);
            r_hop   <= CFG_W'(ofb_pkg::HOP_RESET);
            r_pos   <= '0;
            r_head  <= '0;
            r_count <= '0;
            r_frame <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_win   <= n_win;
            r_hop   <= n_hop;
            r_pos   <= n_pos;
            r_head  <= n_head;
            r_count <= n_count;
            r_frame <= n_frame;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h        <= n_h;
        r_cap      <= n_cap;
        r_s        <= n_s;
        r_o_frame  <= n_o_frame;
        r_o_pos    <= n_o_pos;
        r_o_sample <= n_o_sample;
        r_o_last   <= n_o_last;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ofb_pkg::S_READ) begin
            r_rd <= r_ring[mod_res];
        end
        if (r_state == ofb_pkg::S_WRITE && store) begin
            r_ring[mod_res] <= r_s;
        end
    end

    assign o_cfg_ready      = 1'b1;
    assign o_out_valid      = r_ov;
    assign o_frame_number   = r_o_frame;
    assign o_frame_position = r_o_pos;
    assign o_sample_out     = r_o_sample;
    assign o_last_of_run    = r_o_last;

endmodule

`default_nettype wire

FILE: rtl/ofb_checker.sv
`default_nettype none

module ofb_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_in_valid,
    input wire logic                            o_in_ready,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_ready,
    input wire logic [ofb_pkg::FRAME_W-1:0]     o_frame_number,
    input wire logic [ofb_pkg::POS_W-1:0]       o_frame_position,
    input wire logic [ofb_pkg::IN_SAMPLE_W-1:0] o_sample_out,
    input wire logic                            o_last_of_run
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_frame_number) && $stable(o_frame_position) &&
            $stable(o_sample_out) && $stable(o_last_of_run))
        else $error("result payload changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after an accepted item");

    a_replay_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_of_run |-> !o_in_ready)
        else $error("input ready while a run is unfinished");

endmodule

bind overlapping_frame_buffer ofb_checker u_ofb_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_frame_number   (o_frame_number),
    .o_frame_position (o_frame_position),
    .o_sample_out     (o_sample_out),
    .o_last_of_run    (o_last_of_run)
);

`default_nettype wire
